// File: sv/hdlc_frame_decoder_defines.svh
// Assertion macros shared by the HDLC frame decoder modules.
`ifndef HDLC_FRAME_DECODER_DEFINES_SVH
`define HDLC_FRAME_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define HFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define HFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/hdlc_fd_pkg.sv
// Types, constants and the CRC-16/X.25 byte update for the HDLC frame decoder.
`timescale 1ns / 1ps
`default_nettype none
package hdlc_fd_pkg;

  localparam logic [7:0]  FlagByte = 8'h7E;
  localparam logic [7:0]  EscByte  = 8'h7D;
  localparam logic [7:0]  EscXor   = 8'h20;
  localparam logic [15:0] CrcInit  = 16'hFFFF;
  localparam logic [15:0] CrcPoly  = 16'h8408;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_INVALID      = 2'd1,
    ST_BAD_ESCAPE   = 2'd2,
    ST_CRC_MISMATCH = 2'd3
  } status_e;

  // One classified item between the front and the back.
  typedef struct packed {
    logic    is_end;
    logic [7:0] data;
    status_e status;
  } op_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: sv/hdlc_fd_if.sv
// Valid/ready stream interfaces for raw input bytes and decoder results.
`timescale 1ns / 1ps
`default_nettype none
interface hdlc_fd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       frame_end;

  modport source (output valid, output in_byte, output frame_end, input ready);
  modport sink (input valid, input in_byte, input frame_end, output ready);
endinterface

interface hdlc_fd_out_if;
  logic       valid;
  logic       ready;
  logic       is_status;
  logic [7:0] payload_byte;
  logic [1:0] frame_status;

  modport source (output valid, output is_status, output payload_byte,
                  output frame_status, input ready);
  modport sink (input valid, input is_status, input payload_byte,
                input frame_status, output ready);
endinterface
`default_nettype wire

// File: sv/hdlc_fd_front.sv
// Front end: frame tracking, flag checks and unescaping of raw bytes.
`timescale 1ns / 1ps
`default_nettype none
`include "hdlc_frame_decoder_defines.svh"
module hdlc_fd_front (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  hdlc_fd_in_if.sink       in_i,
  input  wire logic        q_full_i,
  output logic             push_o,
  output hdlc_fd_pkg::op_t push_item_o
);

  logic       start_q, start_d;
  logic       open_q, open_d;
  logic [2:0] cnt_q, cnt_d;
  logic       esc_q, esc_d;
  logic       stop_q, stop_d;
  logic       accept;
  logic [7:0] b;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.in_byte;

  always_comb begin
    start_d     = start_q;
    open_d      = open_q;
    cnt_d       = cnt_q;
    esc_d       = esc_q;
    stop_d      = stop_q;
    push_o      = 1'b0;
    push_item_o = '{is_end: 1'b0, data: b, status: hdlc_fd_pkg::ST_OK};
    if (accept) begin
      if (cnt_q != 3'd7) begin
        cnt_d = cnt_q + 3'd1;
      end
      if (in_i.frame_end) begin
        push_o             = 1'b1;
        push_item_o.is_end = 1'b1;
        push_item_o.data   = 8'h00;
        if (start_q || cnt_q < 3'd3 || !open_q || b != hdlc_fd_pkg::FlagByte) begin
          push_item_o.status = hdlc_fd_pkg::ST_INVALID;
        end else if (esc_q && !stop_q) begin
          push_item_o.status = hdlc_fd_pkg::ST_BAD_ESCAPE;
        end
        start_d = 1'b1;
        open_d  = 1'b0;
        cnt_d   = 3'd0;
        esc_d   = 1'b0;
        stop_d  = 1'b0;
      end else if (start_q) begin
        start_d = 1'b0;
        open_d  = (b == hdlc_fd_pkg::FlagByte);
      end else if (!stop_q) begin
        if (esc_q) begin
          esc_d            = 1'b0;
          push_o           = 1'b1;
          push_item_o.data = b ^ hdlc_fd_pkg::EscXor;
        end else if (b == hdlc_fd_pkg::EscByte) begin
          esc_d = 1'b1;
        end else if (b == hdlc_fd_pkg::FlagByte) begin
          stop_d = 1'b1;
        end else begin
          push_o = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b1;
      open_q  <= 1'b0;
      cnt_q   <= 3'd0;
      esc_q   <= 1'b0;
      stop_q  <= 1'b0;
    end else begin
      start_q <= start_d;
      open_q  <= open_d;
      cnt_q   <= cnt_d;
      esc_q   <= esc_d;
      stop_q  <= stop_d;
    end
  end

  `HFD_ASSERT_NXT(a_end_restarts, accept && in_i.frame_end, start_q && cnt_q == 3'd0, "frame not restarted")
  `HFD_ASSERT_IMP(a_stop_no_data, accept && stop_q && !in_i.frame_end, !push_o, "data after inner flag")

endmodule
`default_nettype wire

// File: sv/hdlc_fd_queue.sv
// Short FIFO of classified items between the front and the back.
`timescale 1ns / 1ps
`default_nettype none
`include "hdlc_frame_decoder_defines.svh"
module hdlc_fd_queue #(
  parameter int Depth = 2
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire hdlc_fd_pkg::op_t  push_item_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output hdlc_fd_pkg::op_t       item_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  hdlc_fd_pkg::op_t    mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  `HFD_ASSERT_IMP(a_no_push_full, full_o, !push_i, "push into full queue")
  `HFD_ASSERT_IMP(a_no_pop_empty, !valid_o, !pop_i, "pop from empty queue")

endmodule
`default_nettype wire

// File: sv/hdlc_fd_back.sv
// Back end: two-byte hold, CRC-16/X.25 and the result register.
`timescale 1ns / 1ps
`default_nettype none
`include "hdlc_frame_decoder_defines.svh"
module hdlc_fd_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             item_valid_i,
  input  wire hdlc_fd_pkg::op_t item_i,
  output logic                  pop_o,
  hdlc_fd_out_if.source         out_o
);

  logic [1:0]  held_cnt_q, held_cnt_d;
  logic [7:0]  held0_q, held0_d;
  logic [7:0]  held1_q, held1_d;
  logic [15:0] crc_q, crc_d;
  logic        out_valid_q, out_valid_d;
  logic        is_status_q, is_status_d;
  logic [7:0]  byte_q, byte_d;
  logic [1:0]  status_q, status_d;
  logic        produce;
  hdlc_fd_pkg::status_e st;

  assign pop_o = item_valid_i && (!out_valid_q || out_o.ready);

  always_comb begin
    held_cnt_d  = held_cnt_q;
    held0_d     = held0_q;
    held1_d     = held1_q;
    crc_d       = crc_q;
    produce     = 1'b0;
    is_status_d = is_status_q;
    byte_d      = byte_q;
    status_d    = status_q;
    st          = item_i.status;
    if (pop_o) begin
      if (item_i.is_end) begin
        if (item_i.status == hdlc_fd_pkg::ST_OK) begin
          if (held_cnt_q != 2'd2) begin
            st = hdlc_fd_pkg::ST_INVALID;
          end else if ({held1_q, held0_q} != ~crc_q) begin
            st = hdlc_fd_pkg::ST_CRC_MISMATCH;
          end
        end
        produce     = 1'b1;
        is_status_d = 1'b1;
        byte_d      = 8'h00;
        status_d    = st;
        held_cnt_d  = 2'd0;
        held0_d     = 8'h00;
        held1_d     = 8'h00;
        crc_d       = hdlc_fd_pkg::CrcInit;
      end else if (held_cnt_q == 2'd2) begin
        produce     = 1'b1;
        is_status_d = 1'b0;
        byte_d      = held0_q;
        status_d    = hdlc_fd_pkg::ST_OK;
        crc_d       = hdlc_fd_pkg::crc_byte(crc_q, held0_q);
        held0_d     = held1_q;
        held1_d     = item_i.data;
      end else begin
        if (held_cnt_q == 2'd0) begin
          held0_d = item_i.data;
        end else begin
          held1_d = item_i.data;
        end
        held_cnt_d = held_cnt_q + 2'd1;
      end
    end
    if (produce) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt_q  <= 2'd0;
      held0_q     <= 8'h00;
      held1_q     <= 8'h00;
      crc_q       <= hdlc_fd_pkg::CrcInit;
      out_valid_q <= 1'b0;
    end else begin
      held_cnt_q  <= held_cnt_d;
      held0_q     <= held0_d;
      held1_q     <= held1_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_status_q <= is_status_d;
    byte_q      <= byte_d;
    status_q    <= status_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.is_status    = is_status_q;
  assign out_o.payload_byte = byte_q;
  assign out_o.frame_status = status_q;

  `HFD_ASSERT_NXT(a_end_clears, pop_o && item_i.is_end, held_cnt_q == 2'd0 && crc_q == hdlc_fd_pkg::CrcInit, "hold not cleared")
  `HFD_ASSERT_IMP(a_held_range, 1'b1, held_cnt_q != 2'd3, "hold count overflow")

endmodule
`default_nettype wire

// File: sv/hdlc_frame_decoder.sv
// Top level of the HDLC frame decoder: front, item queue and back.
`timescale 1ns / 1ps
`default_nettype none
// HDLC asynchronous deframer with CRC-16/X.25 check. Feed the raw bytes of one
// frame, flags and escapes included, with frame_end on the closing byte. Decoded
// bytes come out as provisional payload items, two decoded bytes behind the
// input (the last two are the received CRC and never leave), and every frame
// ends with one status item: ok, invalid frame, bad escape or CRC mismatch.
// Drop the frame's payload unless the status is ok. The block takes one byte
// per clock cycle while out_o.ready stays high; back-pressure fills the item
// queue and then drops in_i.ready. A result passes through the item queue and
// then the output register. QueueDepth must be at least 2.
module hdlc_frame_decoder #(
  parameter int QueueDepth = 2
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  hdlc_fd_in_if.sink    in_i,
  hdlc_fd_out_if.source out_o
);

  logic             push;
  hdlc_fd_pkg::op_t push_item;
  logic             q_full;
  logic             q_valid;
  hdlc_fd_pkg::op_t q_item;
  logic             pop;

  hdlc_fd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_item_o (push_item)
  );

  hdlc_fd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .item_o      (q_item)
  );

  hdlc_fd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule
`default_nettype wire
